FILE: design/spi_cmd_pkg.sv
// Shared types and codes for the byte-stream SPI command decoder.
// Has no dependencies; the interfaces and the top level import it.
package spi_cmd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 7;
  localparam int unsigned TargetW = 2;

  localparam logic [ByteW-1:0]   CmdDeselect = 8'h00;
  localparam logic [ByteW-1:0]   CmdExtended = 8'h80;
  localparam logic [ByteW-1:0]   LenMask     = 8'b0111_1111;
  localparam logic [ByteW-1:0]   ExtMax      = 8'h02;

  typedef logic [TargetW-1:0] target_t;
  typedef logic [LenW-1:0]    len_t;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_DESELECT  = 3'd1,
    OP_READ      = 3'd2,
    OP_WRITE_SEL = 3'd3,
    OP_DATA      = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_COMMAND  = 3'b001,
    ST_DATA     = 3'b010,
    ST_EXTENDED = 3'b100
  } parse_state_t;

  typedef struct packed {
    op_t              op;
    target_t          target;
    len_t             read_length;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } result_t;

endpackage

FILE: design/spi_cmd_if.sv
// Valid/ready channel interfaces for the SPI command decoder.
// Depends on spi_cmd_pkg for the payload types.
interface spi_cmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface spi_cmd_out_if;
  logic                 valid;
  logic                 ready;
  spi_cmd_pkg::op_t     op;
  spi_cmd_pkg::target_t target;
  spi_cmd_pkg::len_t    read_length;
  logic [7:0]           data_byte;
  logic                 last_byte;

  modport source (output valid, output op, output target, output read_length,
                  output data_byte, output last_byte, input ready);
  modport sink (input valid, input op, input target, input read_length,
                input data_byte, input last_byte, output ready);
endinterface

FILE: design/byte_stream_spi_command_decoder.sv
// The result of an accepted item is held in the output register from the next cycle.
// Throughput: one item per cycle; the output register is refilled in the same
// cycle that its result is taken, so the input stalls only while a result waits
// and the output is not ready.
// Reset (synchronous, rst_n low): command state, fpga target, burst counters
// cleared and no result pending.
// Top level of the byte-stream SPI command decoder; depends on spi_cmd_pkg
// and the channel interfaces in spi_cmd_if.sv.
module byte_stream_spi_command_decoder (
  input  logic                clk,
  input  logic                rst_n,
  spi_cmd_in_if.sink          in_ch,
  spi_cmd_out_if.source       out_ch
);
  import spi_cmd_pkg::*;

  parse_state_t     state_r, state_nxt;
  target_t          target_r, target_nxt;
  len_t             total_r, total_nxt;
  len_t             count_r, count_nxt;
  len_t             count_inc;
  result_t          res_r, res_nxt;
  logic             out_valid_r;
  logic             accept;
  logic [ByteW-1:0] b;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign count_inc   = count_r + len_t'(1);

  always_comb begin
    state_nxt           = state_r;
    target_nxt          = target_r;
    total_nxt           = total_r;
    count_nxt           = count_r;
    res_nxt.op          = OP_NONE;
    res_nxt.read_length = '0;
    res_nxt.data_byte   = '0;
    res_nxt.last_byte   = 1'b0;
    unique case (state_r)
      ST_DATA: begin
        res_nxt.op        = OP_DATA;
        res_nxt.data_byte = b;
        // A stale count at or past the total also closes the burst.
        if (count_r >= total_r || count_inc == total_r) begin
          res_nxt.last_byte = 1'b1;
          total_nxt         = '0;
          count_nxt         = '0;
          state_nxt         = ST_COMMAND;
        end else begin
          count_nxt = count_inc;
        end
      end
      ST_EXTENDED: begin
        if (b <= ExtMax) begin
          target_nxt = target_t'(b);
        end
        state_nxt = ST_COMMAND;
      end
      default: begin
        state_nxt = ST_COMMAND;
        if (b == CmdDeselect) begin
          res_nxt.op = OP_DESELECT;
        end else if (b == CmdExtended) begin
          state_nxt = ST_EXTENDED;
        end else if (b[ByteW-1]) begin
          res_nxt.op          = OP_READ;
          res_nxt.read_length = len_t'(b & LenMask);
        end else begin
          res_nxt.op = OP_WRITE_SEL;
          total_nxt  = len_t'(b & LenMask);
          count_nxt  = '0;
          state_nxt  = ST_DATA;
        end
      end
    endcase
    res_nxt.target = target_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COMMAND;
      target_r    <= '0;
      total_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        target_r    <= target_nxt;
        total_r     <= total_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.op          = res_r.op;
  assign out_ch.target      = res_r.target;
  assign out_ch.read_length = res_r.read_length;
  assign out_ch.data_byte   = res_r.data_byte;
  assign out_ch.last_byte   = res_r.last_byte;

endmodule

FILE: bench/tb.sv
// Self-checking bench for the byte-stream SPI command decoder. Directed and random
// host byte streams are checked against an in-bench decoder model.
// Depends on spi_cmd_pkg, the channel interfaces in spi_cmd_if.sv and the top level.
`timescale 1ns / 1ps

module tb;
  import spi_cmd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned MaxReported = 10;

  // Extended command values that pick a chip select target.
  localparam logic [ByteW-1:0] ExtFpga  = 8'h00;
  localparam logic [ByteW-1:0] ExtSram  = 8'h01;
  localparam logic [ByteW-1:0] ExtFlash = 8'h02;

  logic clk = 1'b0;
  logic rst_n;

  spi_cmd_in_if  in_ch ();
  spi_cmd_out_if out_ch ();

  byte_stream_spi_command_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Decoder model state.
  parse_state_t dec_state    = ST_COMMAND;
  target_t      dec_target   = '0;
  len_t         burst_total  = '0;
  len_t         burst_count  = '0;

  result_t      pending_actions[$];
  int unsigned  mismatches   = 0;
  int unsigned  items_sent   = 0;
  int unsigned  cycle_count  = 0;
  int unsigned  burst_left   = 0;
  bit           sender_gaps  = 1'b1;
  result_t      want;

  function automatic result_t decode_host_byte(input logic [ByteW-1:0] b);
    result_t r;
    len_t    next_count;
    r = '0;
    r.op = OP_NONE;
    case (dec_state)
      ST_DATA: begin
        next_count  = burst_count + len_t'(1);
        r.op        = OP_DATA;
        r.data_byte = b;
        if (burst_count >= burst_total || next_count == burst_total) begin
          r.last_byte = 1'b1;
          burst_total = '0;
          burst_count = '0;
          dec_state   = ST_COMMAND;
        end else begin
          burst_count = next_count;
        end
      end
      ST_EXTENDED: begin
        if (b <= ExtMax) dec_target = b[TargetW-1:0];
        dec_state = ST_COMMAND;
      end
      default: begin
        if (b == CmdDeselect) begin
          r.op = OP_DESELECT;
          dec_state = ST_COMMAND;
        end else if (b == CmdExtended) begin
          dec_state = ST_EXTENDED;
        end else if (b[ByteW-1]) begin
          r.op          = OP_READ;
          r.read_length = len_t'(b & LenMask);
          dec_state     = ST_COMMAND;
        end else begin
          r.op        = OP_WRITE_SEL;
          burst_total = len_t'(b & LenMask);
          burst_count = '0;
          dec_state   = ST_DATA;
        end
      end
    endcase
    r.target = dec_target;
    return r;
  endfunction

  // Sends one item; the sender runs in bursts with random gaps unless gaps are off.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (sender_gaps && burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_actions.push_back(decode_host_byte(b));
    items_sent++;
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
  endtask

  task automatic test_deselect_and_reads();
    send_byte(CmdDeselect);
    send_byte({1'b1, 7'd1});
    send_byte({1'b1, 7'd127});
    send_byte({1'b1, 7'h45});
    send_byte(CmdDeselect);
  endtask

  task automatic test_extended_targets();
    send_byte(CmdExtended);
    send_byte(ExtSram);
    send_byte({1'b1, 7'd3});
    send_byte(CmdExtended);
    send_byte(ExtFlash);
    // Unknown extended values must leave the flash target in place.
    send_byte(CmdExtended);
    send_byte(ExtFlash + 8'd1);
    send_byte(CmdExtended);
    send_byte(8'hFF);
    send_byte(CmdExtended);
    send_byte(CmdExtended);
    send_byte(CmdExtended);
    send_byte(ExtFpga);
  endtask

  task automatic test_write_bursts();
    send_byte(8'd1);
    send_byte(8'hFF);
    // Command codes inside a burst are plain data.
    send_byte(8'd3);
    send_byte(CmdDeselect);
    send_byte(CmdExtended);
    send_byte(8'h7F);
  endtask

  task automatic send_write_burst(input int unsigned len, input int unsigned sent_len);
    send_byte(ByteW'(len));
    repeat (sent_len) send_byte(ByteW'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed commands with random content; some noise and short bursts.
  task automatic send_random_command();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      len = $urandom_range(0, 99);
      if (len < 85) len = $urandom_range(1, 8);
      else if (len < 97) len = $urandom_range(9, 126);
      else len = 127;
      send_write_burst(len, len);
    end else if (kind < 58) begin
      send_byte({1'b1, len_t'($urandom_range(1, 127))});
    end else if (kind < 68) begin
      send_byte(CmdDeselect);
    end else if (kind < 82) begin
      send_byte(CmdExtended);
      send_byte(ByteW'($urandom_range(0, 2)));
    end else if (kind < 87) begin
      send_byte(CmdExtended);
      send_byte(ByteW'($urandom_range(3, 255)));
    end else if (kind < 92) begin
      // A burst cut short, so that following commands are eaten as data.
      len = $urandom_range(2, 12);
      send_write_burst(len, $urandom_range(0, len - 1));
    end else begin
      send_byte(ByteW'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned start_count;
    int unsigned paused;
    start_count = items_sent;
    paused      = 0;
    send_write_burst(127, 127);
    while (items_sent - start_count < RandomItems) begin
      if (paused == 0 && items_sent - start_count > RandomItems / 2) begin
        drain_results();
        paused = 1;
      end
      // Stretches where the sender never idles.
      if ($urandom_range(0, 15) == 0) begin
        sender_gaps = ~sender_gaps;
        burst_left  = 0;
      end
      send_random_command();
    end
    sender_gaps = 1'b1;
  endtask

  // Receiver stall pattern: stretches of always ready, coin flips, ready when a
  // phase counter is a multiple of four, and long stalls.
  initial begin
    int unsigned mode;
    int unsigned stretch;
    int unsigned hold;
    int unsigned phase;
    out_ch.ready = 1'b0;
    stretch = 0;
    hold    = 0;
    phase   = 0;
    mode    = 0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        stretch = $urandom_range(20, 120);
        mode    = $urandom_range(0, 3);
      end
      stretch--;
      phase++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (phase % 4 == 0);
        default: begin
          if (hold == 0) hold = $urandom_range(1, 10);
          hold--;
          out_ch.ready <= (hold == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("unexpected result: op %0d target %0d len %0d data %02h last %0b",
                   out_ch.op, out_ch.target, out_ch.read_length, out_ch.data_byte,
                   out_ch.last_byte);
        end
      end else begin
        want = pending_actions.pop_front();
        if (out_ch.op !== want.op || out_ch.target !== want.target ||
            out_ch.read_length !== want.read_length ||
            out_ch.data_byte !== want.data_byte || out_ch.last_byte !== want.last_byte) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("mismatch: expected op %0d target %0d len %0d data %02h last %0b",
                     want.op, want.target, want.read_length, want.data_byte,
                     want.last_byte);
            $display("          actual   op %0d target %0d len %0d data %02h last %0b",
                     out_ch.op, out_ch.target, out_ch.read_length, out_ch.data_byte,
                     out_ch.last_byte);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL byte_stream_spi_command_decoder");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_deselect_and_reads();
    test_extended_targets();
    test_write_bursts();
    drain_results();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_actions.size() == 0) begin
      $display("PASS byte_stream_spi_command_decoder");
    end else begin
      $display("FAIL byte_stream_spi_command_decoder");
    end
    $finish;
  end

endmodule
